/* rtl/core/polyblep_voice_oscillator_core_macros.svh */
// Assertion helpers for the oscillator core
`ifndef POLYBLEP_VOICE_OSCILLATOR_CORE_MACROS_SVH
`define POLYBLEP_VOICE_OSCILLATOR_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is low
`define PVO_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is low
`define PVO_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/pvo_pkg.sv */
package pvo_pkg;

  localparam int NOTE_COUNT   = 128;
  localparam int SINE_ENTRIES = 256;
  localparam int NOTE_W       = 7;
  localparam int BEND_W       = 14;
  localparam int SAMPLE_W     = 12;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENGINE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_W   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BEND_RNG  = 2'd2;

  localparam logic [95:0] SemiQ32  = 96'd4540449315;
  localparam logic [95:0] A4Inc    = (96'd440 << 32) / 96'd48000;
  localparam logic [63:0] PwMul    = 64'hF000_0000_0000_0000 / 64'd127;
  localparam logic [31:0] PW_BASE  = 32'h0800_0000;

  typedef logic [31:0]        pitch_tab_t [NOTE_COUNT];
  typedef logic signed [11:0] sine_tab_t  [SINE_ENTRIES];
  typedef logic [31:0]        pw_tab_t    [128];

  // Semitone increments, built outward from A4
  function automatic pitch_tab_t pitch_tab_fn();
    pitch_tab_t  t;
    logic [95:0] e;
    e = A4Inc;
    t[69] = e[31:0];
    for (int n = 70; n < NOTE_COUNT; n++) begin
      e = (e * SemiQ32) >> 32;
      e = {64'b0, e[31:0]};
      t[n] = e[31:0];
    end
    e = A4Inc;
    for (int n = 68; n >= 0; n--) begin
      e = (e << 32) / SemiQ32;
      e = {64'b0, e[31:0]};
      t[n] = e[31:0];
    end
    return t;
  endfunction

  // Sine table by fixed-point rotation
  function automatic sine_tab_t sine_tab_fn();
    sine_tab_t      t;
    longint signed  s, c, ns, nc;
    longint signed  v;
    s = 0;
    c = 32767;
    for (int n = 0; n < SINE_ENTRIES; n++) begin
      v    = (s * 2047) >>> 15;
      t[n] = 12'(v);
      ns   = ((s * 32757) >>> 15) + ((c * 804) >>> 15);
      nc   = ((c * 32757) >>> 15) - ((s * 804) >>> 15);
      s    = ns;
      c    = nc;
    end
    return t;
  endfunction

  // Pulse thresholds for each duty setting
  function automatic pw_tab_t pw_tab_fn();
    pw_tab_t     t;
    logic [63:0] m;
    for (int n = 0; n < 128; n++) begin
      m    = 64'(n) * PwMul;
      t[n] = m[63:32] + PW_BASE;
    end
    return t;
  endfunction

  localparam pitch_tab_t PITCH_ROM = pitch_tab_fn();
  localparam sine_tab_t  SINE_ROM  = sine_tab_fn();
  localparam pw_tab_t    PW_TAB    = pw_tab_fn();

endpackage

/* rtl/core/pvo_if.sv */
interface pvo_in_if
  import pvo_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [NOTE_W-1:0]        note;
  logic signed [BEND_W-1:0] bend;
  modport source (output valid, note, bend, input ready);
  modport sink (input valid, note, bend, output ready);
endinterface

interface pvo_out_if
  import pvo_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

/* rtl/core/polyblep_voice_oscillator_core.sv */
// Channel   Dir  Payload                     Handshake
// in_if     in   note[6:0], bend[13:0] s     valid/ready
// out_if    out  sample[11:0] s              valid/ready
// cfg       in   cfg_index[1:0], cfg_wdata   cfg_we, no stall
//
// The pulse, sine and triangle engines finish in one waveform pass; the dual
// sine and pulse-plus-sub engines add a second pass. Each saw with a nonzero
// increment runs the 33-step reciprocal divider and the shared 34x34 multiplier,
// and the sub square adds a pass. Reset is synchronous, active low, clears
// phases and control and sets the configuration defaults. A waiting result
// holds the block in its output state until taken; input is taken only when the sequencer idles.
`include "polyblep_voice_oscillator_core_macros.svh"

module polyblep_voice_oscillator_core
  import pvo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  pvo_in_if.sink                in_if,
  pvo_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_BEND, S_N8, S_INTP, S_INC, S_PHASE, S_WAVE,
    S_DIV, S_M1, S_M1C, S_M2C, S_FIN1, S_FIN2, S_OUT
  } state_t;

  typedef enum logic [2:0] {WK_PULSE, WK_SINE, WK_SAW, WK_TRI, WK_SQUARE} wave_kind_t;

  localparam logic [2:0] ENG_PULSE    = 3'd0;
  localparam logic [2:0] ENG_SINE     = 3'd1;
  localparam logic [2:0] ENG_SAW      = 3'd2;
  localparam logic [2:0] ENG_TRI      = 3'd3;
  localparam logic [2:0] ENG_DUAL_SAW = 3'd4;
  localparam logic [2:0] ENG_PLS_SUB  = 3'd5;
  localparam logic [2:0] ENG_DUAL_SIN = 3'd6;
  localparam logic [2:0] ENG_SAW_SUB  = 3'd7;
  localparam int         DIV_STEPS    = 33;
  localparam logic [5:0] DIV_LAST     = 6'(DIV_STEPS - 1);

  state_t                     state_r;
  logic [2:0]                 engine_r;
  logic [6:0]                 pulse_width_r;
  logic [5:0]                 bend_range_r;
  logic [31:0]                mph_r, sph_r, inc_r, inc2_r;
  logic [NOTE_W-1:0]          note_r;
  logic signed [BEND_W-1:0]   bend_r;
  logic [6:0]                 k0_r;
  logic [7:0]                 fr_r;
  logic signed [67:0]         prod_r;
  logic [32:0]                rem_r, quo_r;
  logic [5:0]                 cnt_r;
  logic [15:0]                x_r;
  logic                       pass_r;
  logic signed [11:0]         wa_r, res_r;
  logic                       out_valid_r;
  logic signed [11:0]         out_sample_r;

  logic signed [33:0]         mul_a, mul_b;
  logic [31:0]                cur_ph, cur_inc;
  wave_kind_t                 kind;
  logic                       wave_done;
  logic signed [11:0]         wave_val;
  logic [6:0]                 k1;
  logic signed [32:0]         i_diff;
  logic signed [19:0]         n8;
  logic [32:0]                rem_sh;
  logic                       div_ge;
  logic signed [12:0]         dual_sum;

  // Clamp a signed value to the sample range
  function automatic logic signed [11:0] clip12(input logic signed [18:0] v);
    if (v < -19'sd2048) return -12'sd2048;
    if (v > 19'sd2047) return 12'sd2047;
    return v[11:0];
  endfunction

  // Naive saw minus its band-limiting correction
  function automatic logic signed [11:0] saw_val(input logic [31:0] ph,
                                                 input logic signed [12:0] corr);
    logic signed [18:0] s;
    s = $signed({7'b0, ph[31:20]}) - 19'sd2048 - 19'(corr);
    return clip12(s);
  endfunction

  assign cur_ph  = pass_r ? sph_r : mph_r;
  assign cur_inc = pass_r ? inc2_r : inc_r;
  assign k1      = (k0_r == 7'd127) ? 7'd127 : k0_r + 7'd1;
  assign i_diff  = $signed({1'b0, PITCH_ROM[k1]}) - $signed({1'b0, PITCH_ROM[k0_r]});
  assign rem_sh  = {rem_r[31:0], quo_r[32]};
  assign div_ge  = rem_sh >= {1'b0, cur_inc};
  assign dual_sum = 13'(wa_r) + 13'(wave_val);

  // Bent note in 1/256 semitone, clamped to the table
  always_comb begin
    n8 = $signed({5'b0, note_r, 8'b0}) + 20'($signed(prod_r[20:0]) >>> 5);
    if (n8 < 20'sd0) n8 = 20'sd0;
    if (n8 > 20'sd32512) n8 = 20'sd32512;
  end

  // Pick the waveform for the current pass
  always_comb begin
    kind = WK_PULSE;
    if (!pass_r) begin
      unique case (engine_r) inside
        ENG_PULSE, ENG_PLS_SUB:               kind = WK_PULSE;
        ENG_SINE, ENG_DUAL_SIN:               kind = WK_SINE;
        ENG_SAW, ENG_DUAL_SAW, ENG_SAW_SUB:   kind = WK_SAW;
        ENG_TRI:                              kind = WK_TRI;
        default:                              kind = WK_PULSE;
      endcase
    end else begin
      unique case (engine_r) inside
        ENG_DUAL_SAW:               kind = WK_SAW;
        ENG_DUAL_SIN:               kind = WK_SINE;
        ENG_PLS_SUB, ENG_SAW_SUB:   kind = WK_SQUARE;
        default:                    kind = WK_SQUARE;
      endcase
    end
  end

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_BEND: begin
        mul_a = 34'(bend_r);
        mul_b = {28'b0, bend_range_r};
      end
      S_INTP: begin
        mul_a = 34'(i_diff);
        mul_b = {26'b0, fr_r};
      end
      S_M1: begin
        mul_a = {2'b0, cur_ph};
        mul_b = {2'b0, quo_r[31:0]};
      end
      S_M1C: begin
        if (prod_r[63:32] == 32'b0) begin
          mul_a = {18'b0, prod_r[31:16]};
          mul_b = {18'b0, prod_r[31:16]};
        end else begin
          mul_a = {2'b0, 32'(0) - cur_ph};
          mul_b = {2'b0, quo_r[31:0]};
        end
      end
      S_M2C: begin
        mul_a = {17'b0, 17'(17'd65536 - {1'b0, prod_r[31:16]})};
        mul_b = mul_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Finish a waveform value
  always_comb begin
    logic signed [18:0] t;
    logic signed [18:0] c1;
    wave_done = 1'b0;
    wave_val  = '0;
    t         = '0;
    c1        = '0;
    case (state_r)
      S_WAVE: begin
        case (kind)
          WK_PULSE: begin
            wave_done = 1'b1;
            wave_val  = (cur_ph < PW_TAB[pulse_width_r]) ? 12'sd2047 : -12'sd2048;
          end
          WK_SINE: begin
            wave_done = 1'b1;
            wave_val  = SINE_ROM[cur_ph[31:24]];
          end
          WK_TRI: begin
            wave_done = 1'b1;
            if (!cur_ph[31])
              t = $signed({2'b0, cur_ph[31:16], 1'b0}) - 19'sd32768;
            else
              t = 19'sd98304 - $signed({2'b0, cur_ph[31:16], 1'b0});
            wave_val = clip12(t >>> 4);
          end
          WK_SQUARE: begin
            wave_done = 1'b1;
            wave_val  = cur_ph[31] ? 12'sd2047 : -12'sd2048;
          end
          default: begin
            wave_done = (cur_inc == 32'b0);
            wave_val  = saw_val(cur_ph, 13'sd0);
          end
        endcase
      end
      S_M1: begin
        wave_done = (quo_r[31:0] == 32'b0);
        wave_val  = saw_val(cur_ph, 13'sd0);
      end
      S_M2C: begin
        wave_done = (prod_r[63:32] != 32'b0);
        wave_val  = saw_val(cur_ph, 13'sd0);
      end
      S_FIN1: begin
        wave_done = 1'b1;
        c1 = $signed({2'b0, x_r, 1'b0}) - $signed({3'b0, prod_r[31:16]}) - 19'sd65536;
        wave_val = saw_val(cur_ph, 13'(c1 >>> 5));
      end
      S_FIN2: begin
        wave_done = 1'b1;
        wave_val  = saw_val(cur_ph, $signed({1'b0, prod_r[32:21]}));
      end
      default: begin
        wave_done = 1'b0;
        wave_val  = '0;
      end
    endcase
  end

  assign in_if.ready   = (state_r == S_IDLE);
  assign out_if.valid  = out_valid_r;
  assign out_if.sample = out_sample_r;

  // Sequencer, datapath and registered outputs
  always_ff @(posedge clk) begin
    prod_r <= 68'(mul_a) * 68'(mul_b);
    if (!rst_n) begin
      state_r       <= S_IDLE;
      engine_r      <= ENG_PULSE;
      pulse_width_r <= 7'd64;
      bend_range_r  <= 6'd2;
      mph_r         <= '0;
      sph_r         <= '0;
      pass_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENGINE:   engine_r      <= cfg_wdata[2:0];
          CFG_PULSE_W:  pulse_width_r <= cfg_wdata;
          CFG_BEND_RNG: bend_range_r  <= cfg_wdata[5:0];
          default:      ;
        endcase
      end
      // Drop a taken result unless a new one replaces it
      if (out_valid_r && out_if.ready && state_r != S_OUT) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            note_r  <= in_if.note;
            bend_r  <= in_if.bend;
            state_r <= S_BEND;
          end
        end
        S_BEND: state_r <= S_N8;
        S_N8: begin
          k0_r    <= n8[14:8];
          fr_r    <= n8[7:0];
          state_r <= S_INTP;
        end
        S_INTP: state_r <= S_INC;
        S_INC: begin
          inc_r   <= PITCH_ROM[k0_r] + prod_r[39:8];
          state_r <= S_PHASE;
        end
        S_PHASE: begin
          // Advance the accumulators
          mph_r <= mph_r + inc_r;
          if (engine_r[2]) begin
            case (engine_r)
              ENG_DUAL_SAW: begin
                inc2_r <= inc_r + (inc_r >> 7);
                sph_r  <= sph_r + inc_r + (inc_r >> 7);
              end
              ENG_DUAL_SIN: begin
                inc2_r <= inc_r + (inc_r >> 8);
                sph_r  <= sph_r + inc_r + (inc_r >> 8);
              end
              default: begin
                inc2_r <= inc_r >> 1;
                sph_r  <= sph_r + (inc_r >> 1);
              end
            endcase
          end
          state_r <= S_WAVE;
        end
        S_WAVE: begin
          if (!wave_done) begin
            rem_r   <= '0;
            quo_r   <= {1'b1, 32'b0};
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // One restoring step of 2^32 / inc
          rem_r <= div_ge ? rem_sh - {1'b0, cur_inc} : rem_sh;
          quo_r <= {quo_r[31:0], div_ge};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == DIV_LAST) state_r <= S_M1;
        end
        S_M1: if (!wave_done) state_r <= S_M1C;
        S_M1C: begin
          x_r     <= prod_r[31:16];
          state_r <= (prod_r[63:32] == 32'b0) ? S_FIN1 : S_M2C;
        end
        S_M2C:  if (!wave_done) state_r <= S_FIN2;
        S_FIN1: ;
        S_FIN2: ;
        S_OUT: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= res_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // Hand the finished waveform on
      if (wave_done) begin
        if (!pass_r && engine_r[2]) begin
          wa_r    <= wave_val;
          pass_r  <= 1'b1;
          state_r <= S_WAVE;
        end else begin
          res_r   <= engine_r[2] ? dual_sum[12:1] : wave_val;
          pass_r  <= 1'b0;
          state_r <= S_OUT;
        end
      end
    end
  end

  `PVO_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_if.valid && in_if.ready, !in_if.ready, "ready stayed high after an accepted item")
  `PVO_ASSERT_IMP(a_div_nonzero, clk, rst_n, state_r == S_DIV, cur_inc != 32'b0, "divider running on a zero increment")
  `PVO_ASSERT_IMP(a_out_from_seq, clk, rst_n, $rose(out_valid_r), $past(state_r == S_OUT), "result appeared outside the output state")
  `PVO_ASSERT_IMP(a_second_pass_dual, clk, rst_n, pass_r, engine_r[2], "second pass on a single-oscillator engine")

endmodule

/* test/tb_polyblep_voice_oscillator_core.sv */
module tb_polyblep_voice_oscillator_core;
  import pvo_pkg::*;

  // Engine codes
  localparam logic [2:0] ENG_PULSE     = 3'd0;
  localparam logic [2:0] ENG_SINE      = 3'd1;
  localparam logic [2:0] ENG_SAW       = 3'd2;
  localparam logic [2:0] ENG_TRI       = 3'd3;
  localparam logic [2:0] ENG_DUAL_SAW  = 3'd4;
  localparam logic [2:0] ENG_PULSE_SUB = 3'd5;
  localparam logic [2:0] ENG_DUAL_SINE = 3'd6;
  localparam logic [2:0] ENG_SAW_SUB   = 3'd7;

  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 120;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pvo_in_if in_ch ();
  pvo_out_if out_ch ();

  polyblep_voice_oscillator_core dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predictor state and settings
  logic [2:0] osc_engine;
  logic [6:0] osc_pw;
  logic [5:0] osc_range;
  logic [31:0] phase_a;
  logic [31:0] phase_b;
  logic [31:0] semi_tab [NOTE_COUNT];
  logic signed [11:0] sin_tab [SINE_ENTRIES];

  logic signed [11:0] sample_q [$];
  int fails;
  bit quiet;
  int idle_cycles;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Build the semitone and sine tables
  task automatic build_tables();
    logic [95:0] e;
    longint s, c, ns, nc;
    e = (96'd440 << 32) / 96'd48000;
    semi_tab[69] = e[31:0];
    for (int n = 70; n < NOTE_COUNT; n++) begin
      e = ({64'd0, semi_tab[n-1]} * 96'd4540449315) >> 32;
      semi_tab[n] = e[31:0];
    end
    for (int n = 68; n >= 0; n--) begin
      e = ({64'd0, semi_tab[n+1]} << 32) / 96'd4540449315;
      semi_tab[n] = e[31:0];
    end
    s = 0;
    c = 32767;
    for (int n = 0; n < SINE_ENTRIES; n++) begin
      sin_tab[n] = 12'((s * 2047) >>> 15);
      ns = ((s * 32757) >>> 15) + ((c * 804) >>> 15);
      nc = ((c * 32757) >>> 15) - ((s * 804) >>> 15);
      s = ns;
      c = nc;
    end
  endtask

  function automatic longint clamp12(longint x);
    if (x < -2048) return -2048;
    if (x > 2047) return 2047;
    return x;
  endfunction

  function automatic logic [31:0] bent_increment(logic [6:0] note, logic signed [13:0] bend);
    longint n8, d, b;
    int k0, k1, fr;
    b = bend;
    n8 = (longint'(note) << 8) + ((b * longint'(osc_range) * 256) >>> 13);
    if (n8 < 0) n8 = 0;
    if (n8 > (127 << 8)) n8 = 127 << 8;
    k0 = int'(n8 >> 8);
    fr = int'(n8 & 255);
    k1 = (k0 + 1 > 127) ? 127 : k0 + 1;
    d = ((longint'(semi_tab[k1]) - longint'(semi_tab[k0])) * fr) >>> 8;
    return 32'(longint'(semi_tab[k0]) + d);
  endfunction

  // Band-limiting correction near the wrap
  function automatic longint blep_corr(logic [31:0] ph, logic [31:0] r);
    logic [63:0] p;
    longint x, cr;
    if (r == 0) return 0;
    p = 64'(ph) * 64'(r);
    if (p < 64'h1_0000_0000) begin
      x = longint'(p >> 16);
      cr = 2 * x - ((x * x) >> 16) - 65536;
      return (cr * 2048) >>> 16;
    end
    p = 64'(32'(0 - ph)) * 64'(r);
    if (p < 64'h1_0000_0000) begin
      x = 65536 - longint'(p >> 16);
      cr = (x * x) >> 16;
      return (cr * 2048) >>> 16;
    end
    return 0;
  endfunction

  function automatic longint saw_wave(logic [31:0] ph, logic [31:0] inc);
    longint s;
    logic [63:0] r;
    s = longint'(ph >> 20) - 2048;
    if (inc != 0) begin
      r = 64'h1_0000_0000 / 64'(inc);
      s -= blep_corr(ph, r[31:0]);
    end
    return clamp12(s);
  endfunction

  function automatic longint square_wave(logic [31:0] ph);
    return ph[31] ? 2047 : -2048;
  endfunction

  function automatic longint pulse_wave(logic [31:0] ph);
    logic [71:0] m;
    logic [31:0] w;
    m = 72'(osc_pw) * 72'(64'hF000_0000_0000_0000 / 64'd127);
    w = m[63:32] + 32'h0800_0000;
    return (ph < w) ? 2047 : -2048;
  endfunction

  function automatic longint sine_wave(logic [31:0] ph);
    return sin_tab[ph[31:24]];
  endfunction

  function automatic longint tri_wave(logic [31:0] ph);
    longint p, t;
    p = longint'(ph >> 16);
    t = (p < 32768) ? (2 * p - 32768) : (98304 - 2 * p);
    return clamp12(t >>> 4);
  endfunction

  // Advance the phases and form the next sample
  function automatic logic signed [11:0] next_sample(logic [6:0] note,
                                                     logic signed [13:0] bend);
    logic [31:0] inc, inc2;
    longint r;
    inc = bent_increment(note, bend);
    phase_a = phase_a + inc;
    case (osc_engine)
      ENG_DUAL_SAW: begin
        inc2 = inc + (inc >> 7);
        phase_b = phase_b + inc2;
        r = (saw_wave(phase_a, inc) + saw_wave(phase_b, inc2)) >>> 1;
      end
      ENG_PULSE_SUB: begin
        phase_b = phase_b + (inc >> 1);
        r = (pulse_wave(phase_a) + square_wave(phase_b)) >>> 1;
      end
      ENG_DUAL_SINE: begin
        inc2 = inc + (inc >> 8);
        phase_b = phase_b + inc2;
        r = (sine_wave(phase_a) + sine_wave(phase_b)) >>> 1;
      end
      ENG_SAW_SUB: begin
        phase_b = phase_b + (inc >> 1);
        r = (saw_wave(phase_a, inc) + square_wave(phase_b)) >>> 1;
      end
      ENG_SINE: r = sine_wave(phase_a);
      ENG_SAW:  r = saw_wave(phase_a, inc);
      ENG_TRI:  r = tri_wave(phase_a);
      default:  r = pulse_wave(phase_a);
    endcase
    return 12'(r);
  endfunction

  // Register write while idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFG_DATA_W'(val);
    if (idx == CFG_ENGINE) osc_engine = 3'(val);
    else if (idx == CFG_PULSE_W) osc_pw = 7'(val);
    else if (idx == CFG_BEND_RNG) osc_range = 6'(val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    while (sample_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Offer one item; called at a falling edge, returns at a falling edge
  task automatic send_note(logic [6:0] note, logic signed [13:0] bend,
                           bit typed, logic signed [11:0] typed_val);
    logic signed [11:0] s;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.note = note;
    in_ch.bend = bend;
    do @(posedge clk); while (!in_ch.ready);
    s = next_sample(note, bend);
    sample_q.push_back(typed ? typed_val : s);
    @(negedge clk);
  endtask

  task automatic random_notes(int n);
    logic signed [13:0] b;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: b = 14'($urandom);
        1: b = 14'sd0;
        default: b = 14'($signed($urandom_range(0, 1024)) - 512);
      endcase
      send_note(7'($urandom), b, 1'b0, '0);
    end
    in_ch.valid = 1'b0;
  endtask

  // Result side: random stall bursts
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready = 1'b0;
        stall = $urandom_range(1, 14) - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Compare each taken item with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sample_q.size() == 0) begin
        $error("sample: none expected, actual %0d", out_ch.sample);
        fails++;
      end else begin
        if (out_ch.sample !== sample_q[0]) begin
          $error("sample: expected %0d actual %0d", sample_q[0], out_ch.sample);
          fails++;
        end
        void'(sample_q.pop_front());
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_polyblep_voice_oscillator_core NOT OK");
      $finish;
    end
  end

  typedef struct {
    logic [6:0] note;
    logic signed [13:0] bend;
    bit typed;
    logic signed [11:0] val;
  } note_row_t;

  note_row_t rows [] = '{
    '{7'd0,   14'sd0,     1'b1, 12'sd2047},
    '{7'd127, 14'sd8191,  1'b0, 12'sd0},
    '{7'd0,   -14'sd8192, 1'b0, 12'sd0},
    '{7'd127, -14'sd8192, 1'b0, 12'sd0},
    '{7'd0,   14'sd8191,  1'b0, 12'sd0},
    '{7'd69,  14'sd0,     1'b0, 12'sd0},
    '{7'd69,  14'sd4096,  1'b0, 12'sd0},
    '{7'd69,  -14'sd4096, 1'b0, 12'sd0},
    '{7'd126, 14'sd8191,  1'b0, 12'sd0},
    '{7'd1,   -14'sd1,    1'b0, 12'sd0},
    '{7'd85,  14'sd5461,  1'b0, 12'sd0},
    '{7'd42,  -14'sd2731, 1'b0, 12'sd0},
    '{7'd127, 14'sd0,     1'b0, 12'sd0},
    '{7'd100, 14'sd1,     1'b0, 12'sd0}
  };

  initial begin
    int eng;
    fails = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.note = '0;
    in_ch.bend = '0;
    osc_engine = ENG_PULSE;
    osc_pw = 7'd64;
    osc_range = 6'd2;
    phase_a = '0;
    phase_b = '0;
    build_tables();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table at reset settings
    foreach (rows[i]) send_note(rows[i].note, rows[i].bend, rows[i].typed, rows[i].val);
    in_ch.valid = 1'b0;

    // Walk each engine with extremes of duty and bend range
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      eng = ph % 8;
      write_reg(CFG_ENGINE, eng);
      case (ph % 4)
        0: write_reg(CFG_PULSE_W, 0);
        1: write_reg(CFG_PULSE_W, 127);
        default: write_reg(CFG_PULSE_W, $urandom_range(0, 127));
      endcase
      case (ph % 5)
        0: write_reg(CFG_BEND_RNG, 0);
        1: write_reg(CFG_BEND_RNG, 48);
        2: write_reg(CFG_BEND_RNG, 63);
        default: write_reg(CFG_BEND_RNG, $urandom_range(1, 48));
      endcase
      if (ph == 11) quiet = 1'b1;
      random_notes(100);
    end

    drain();
    if (fails == 0)
      $display("tb_polyblep_voice_oscillator_core OK");
    else
      $display("tb_polyblep_voice_oscillator_core NOT OK");
    $finish;
  end

endmodule
